>>> rtl/ps2mct_pkg.sv
package ps2mct_pkg;

	localparam int POS_BITS      = 10;
	localparam int CURSOR_MARGIN = 16;
	localparam int SIZE_BITS     = 12;
	localparam int OUT_BITS      = 10;
	localparam int RAW_BITS      = POS_BITS + 2;
	localparam int CMP_BITS      = (POS_BITS > SIZE_BITS) ? POS_BITS : SIZE_BITS;
	localparam int TDATA_BITS    = 48;

	localparam logic [SIZE_BITS-1:0] WIDTH_RST  = SIZE_BITS'(640);
	localparam logic [SIZE_BITS-1:0] HEIGHT_RST = SIZE_BITS'(480);

	localparam logic [1:0] PH_STATUS = 2'd0;
	localparam logic [1:0] PH_DX     = 2'd1;
	localparam logic [1:0] PH_DY     = 2'd2;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam int SYNC_BIT  = 3;
	localparam int XSIGN_BIT = 4;
	localparam int YSIGN_BIT = 5;

	typedef struct packed {
		logic [1:0]          pad;
		logic                button_changed;
		logic                any_pressed;
		logic                btn_middle;
		logic                btn_right;
		logic                btn_left;
		logic                moved;
		logic [OUT_BITS-1:0] prev_y;
		logic [OUT_BITS-1:0] prev_x;
		logic [OUT_BITS-1:0] pos_y;
		logic [OUT_BITS-1:0] pos_x;
	} result_t;

	// floor at 0, mask, raise to 1, clamp to screen limit
	function automatic logic [POS_BITS-1:0] place(
		input logic signed [RAW_BITS-1:0] raw,
		input logic [SIZE_BITS-1:0]       size
	);
		logic [SIZE_BITS-1:0] limit;
		logic [POS_BITS-1:0]  v;
		limit = (size > SIZE_BITS'(CURSOR_MARGIN)) ? size - SIZE_BITS'(CURSOR_MARGIN) : '0;
		v = raw[RAW_BITS-1] ? '0 : raw[POS_BITS-1:0];
		if (v == '0) begin
			v = POS_BITS'(1);
		end
		if (CMP_BITS'(v) > CMP_BITS'(limit)) begin
			v = POS_BITS'(limit);
		end
		return v;
	endfunction

endpackage

>>> rtl/ps2_mouse_cursor_tracker.sv
// Each byte is first registered in byte_s1; a packet's third byte then loads the output word register.
// Throughput: one byte per cycle unless the output stalls; only the third byte of a packet yields a word.
// While a word waits, the next packet's first bytes still enter; its third byte holds the input.
// Reset (arst_n low, asynchronous): packet phase, cursor and buttons clear to 0,
// screen size returns to 640 x 480, both stream sides go empty.
module ps2_mouse_cursor_tracker
	import ps2mct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [SIZE_BITS-1:0]  cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // data_byte[7:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pos_x[9:0], pos_y[19:10], prev_x[29:20], prev_y[39:30], moved[40],
	// btn_left[41], btn_right[42], btn_middle[43], any_pressed[44],
	// button_changed[45], zero[47:46]
	output logic [TDATA_BITS-1:0] m_axis_tdata
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic [1:0]           phase_q;
	logic [7:0]           status_q;
	logic [7:0]           dx_q;
	logic [POS_BITS-1:0]  cur_x_q;
	logic [POS_BITS-1:0]  cur_y_q;
	logic [2:0]           last_btn_q;
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	logic                 out_valid_q;
	result_t              out_q;

	logic                       in_acc;
	logic                       adv;
	logic                       emit;
	logic signed [8:0]          dx;
	logic signed [8:0]          dy;
	logic signed [RAW_BITS-1:0] raw_x;
	logic signed [RAW_BITS-1:0] raw_y;
	logic [POS_BITS-1:0]        nx;
	logic [POS_BITS-1:0]        ny;
	logic [2:0]                 hot;
	result_t                    res;

	assign emit          = valid_s1 && (phase_q == PH_DY);
	assign adv           = valid_s1 && (phase_q != PH_DY || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign dx    = {status_q[XSIGN_BIT], dx_q};
	assign dy    = {status_q[YSIGN_BIT], byte_s1};
	assign raw_x = $signed({2'b00, cur_x_q}) + RAW_BITS'(dx);
	assign raw_y = $signed({2'b00, cur_y_q}) - RAW_BITS'(dy);
	assign nx    = place(raw_x, width_q);
	assign ny    = place(raw_y, height_q);

	always_comb begin
		if (status_q[2]) begin
			hot = 3'b100;
		end else if (status_q[1]) begin
			hot = 3'b010;
		end else if (status_q[0]) begin
			hot = 3'b001;
		end else begin
			hot = 3'b000;
		end
		res                = '0;
		res.pos_x          = OUT_BITS'(nx);
		res.pos_y          = OUT_BITS'(ny);
		res.prev_x         = OUT_BITS'(cur_x_q);
		res.prev_y         = OUT_BITS'(cur_y_q);
		res.moved          = (nx != cur_x_q) || (ny != cur_y_q);
		res.btn_left       = hot[0];
		res.btn_right      = hot[1];
		res.btn_middle     = hot[2];
		res.any_pressed    = |status_q[2:0];
		res.button_changed = hot != last_btn_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= s_axis_tdata;
		end
		if (adv && emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_STATUS;
			status_q    <= '0;
			dx_q        <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			last_btn_q  <= '0;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				case (phase_q)
					PH_STATUS: begin
						status_q <= byte_s1;
						phase_q  <= byte_s1[SYNC_BIT] ? PH_DX : PH_STATUS;
					end
					PH_DX: begin
						dx_q    <= byte_s1;
						phase_q <= PH_DY;
					end
					PH_DY: begin
						cur_x_q    <= nx;
						cur_y_q    <= ny;
						last_btn_q <= hot;
						phase_q    <= PH_STATUS;
					end
					default: phase_q <= PH_STATUS;
				endcase
			end
			if (adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

>>> rtl/ps2mct_checker.sv
module ps2mct_checker
	import ps2mct_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [TDATA_BITS-1:0] m_axis_tdata
);

	result_t r;
	assign r = m_axis_tdata;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0({r.btn_middle, r.btn_right, r.btn_left}))
		else $error("buttons not one-hot");

	a_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.any_pressed == (r.btn_middle | r.btn_right | r.btn_left))
		else $error("pressed flag disagrees with buttons");

	a_moved: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.moved == ((r.pos_x != r.prev_x) || (r.pos_y != r.prev_y)))
		else $error("moved flag disagrees with positions");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_ps2mct_checker (.*);

>>> dv/tb_ps2_mouse_cursor_tracker.sv
module tb_ps2_mouse_cursor_tracker
	import ps2mct_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = CFG_WIDTH;
	logic [SIZE_BITS-1:0]  cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;   // data_byte[7:0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// pos_x[9:0], pos_y[19:10], prev_x[29:20], prev_y[39:30], moved[40],
	// btn_left[41], btn_right[42], btn_middle[43], any_pressed[44],
	// button_changed[45], zero[47:46]
	logic [TDATA_BITS-1:0] m_axis_tdata;

	ps2_mouse_cursor_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// tracker model state
	logic [1:0]           phase_q = PH_STATUS;
	logic [7:0]           status_q = '0;
	logic [7:0]           dx_q = '0;
	logic [POS_BITS-1:0]  cur_x = '0;
	logic [POS_BITS-1:0]  cur_y = '0;
	logic [2:0]           last_hot = '0;
	logic [SIZE_BITS-1:0] width_q = WIDTH_RST;
	logic [SIZE_BITS-1:0] height_q = HEIGHT_RST;

	result_t cursor_words[$];
	int      mismatch_count = 0;
	int      bytes_sent = 0;
	int      tx_idle_pct = 7;
	int      rx_idle_pct = 55;

	task automatic report_mismatch(input string what, input logic [TDATA_BITS-1:0] got,
		input logic [TDATA_BITS-1:0] want);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		end
	endtask

	task automatic check_field(input string name, input logic [OUT_BITS-1:0] got,
		input logic [OUT_BITS-1:0] want);
		if (got != want) begin
			report_mismatch(name, TDATA_BITS'(got), TDATA_BITS'(want));
		end
	endtask

	function automatic logic [POS_BITS-1:0] clamp_coord(input int raw, input int size);
		int v;
		int lim;
		v = (raw < 0) ? 0 : raw;
		lim = (size > CURSOR_MARGIN) ? size - CURSOR_MARGIN : 0;
		v = v & ((1 << POS_BITS) - 1);
		if (v < 1) begin
			v = 1;
		end
		if (v > lim) begin
			v = lim;
		end
		return v[POS_BITS-1:0];
	endfunction

	task automatic track_byte(input logic [7:0] b);
		result_t             w;
		int                  dx;
		int                  dy;
		logic [POS_BITS-1:0] nx;
		logic [POS_BITS-1:0] ny;
		logic [2:0]          hot;
		case (phase_q)
			PH_STATUS: begin
				status_q = b;
				if (b[SYNC_BIT]) begin
					phase_q = PH_DX;
				end
			end
			PH_DX: begin
				dx_q = b;
				phase_q = PH_DY;
			end
			PH_DY: begin
				phase_q = PH_STATUS;
				dx = status_q[XSIGN_BIT] ? int'(dx_q) - 256 : int'(dx_q);
				dy = status_q[YSIGN_BIT] ? int'(b) - 256 : int'(b);
				nx = clamp_coord(int'(cur_x) + dx, int'(width_q));
				ny = clamp_coord(int'(cur_y) - dy, int'(height_q));
				if (status_q[2]) begin
					hot = 3'b100;
				end else if (status_q[1]) begin
					hot = 3'b010;
				end else if (status_q[0]) begin
					hot = 3'b001;
				end else begin
					hot = 3'b000;
				end
				w = '0;
				w.pos_x = nx;
				w.pos_y = ny;
				w.prev_x = cur_x;
				w.prev_y = cur_y;
				w.moved = (nx != cur_x) || (ny != cur_y);
				w.btn_left = hot[0];
				w.btn_right = hot[1];
				w.btn_middle = hot[2];
				w.any_pressed = |status_q[2:0];
				w.button_changed = (hot != last_hot);
				cursor_words.push_back(w);
				last_hot = hot;
				cur_x = nx;
				cur_y = ny;
			end
			default: phase_q = PH_STATUS;
		endcase
	endtask

	// inputs only change at rising edges, so the negedge sees what the next edge takes
	always @(negedge clk) begin : check_words
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (cursor_words.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata, '0);
			end else begin
				want = cursor_words.pop_front();
				check_field("pos_x", got.pos_x, want.pos_x);
				check_field("pos_y", got.pos_y, want.pos_y);
				check_field("prev_x", got.prev_x, want.prev_x);
				check_field("prev_y", got.prev_y, want.prev_y);
				check_field("moved", OUT_BITS'(got.moved), OUT_BITS'(want.moved));
				check_field("btn_left", OUT_BITS'(got.btn_left), OUT_BITS'(want.btn_left));
				check_field("btn_right", OUT_BITS'(got.btn_right),
					OUT_BITS'(want.btn_right));
				check_field("btn_middle", OUT_BITS'(got.btn_middle),
					OUT_BITS'(want.btn_middle));
				check_field("any_pressed", OUT_BITS'(got.any_pressed),
					OUT_BITS'(want.any_pressed));
				check_field("button_changed", OUT_BITS'(got.button_changed),
					OUT_BITS'(want.button_changed));
				check_field("pad", OUT_BITS'(got.pad), OUT_BITS'(want.pad));
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 40) begin
			gap++;
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(negedge clk);
		while (!s_axis_tready) begin
			@(negedge clk);
		end
		track_byte(b);
		bytes_sent++;
		@(posedge clk);
	endtask

	// wait for all words plus the pipeline depth so config changes see an idle block
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (cursor_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_screen(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		width_q = w;
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		height_q = h;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SIZE_BITS-1:0] pick_size(input int k);
		case (k % 6)
			0: return SIZE_BITS'($urandom_range(CURSOR_MARGIN));
			1: return SIZE_BITS'(CURSOR_MARGIN + 1);
			2: return {SIZE_BITS{1'b1}};
			3: return SIZE_BITS'($urandom_range(CURSOR_MARGIN + 1,
				(1 << POS_BITS) + CURSOR_MARGIN));
			4: return SIZE_BITS'($urandom_range((1 << POS_BITS) + CURSOR_MARGIN,
				(1 << SIZE_BITS) - 1));
			default: return SIZE_BITS'($urandom_range((1 << SIZE_BITS) - 1));
		endcase
	endfunction

	// mostly framed packets, some stray bytes that break the framing
	task automatic send_random_unit();
		if ($urandom_range(99) < 12) begin
			send_byte(8'($urandom_range(255)));
		end else begin
			send_byte(8'($urandom_range(255)) | 8'h08);
			send_byte(8'($urandom_range(255)));
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic test_sync_and_buttons();
		logic [7:0] seq [17] = '{
			8'h00, 8'hF7,
			8'h08, 8'h00, 8'h00,
			8'hCF, 8'hFF, 8'h80,
			8'h39, 8'h00, 8'h00,
			8'h0A, 8'h7F, 8'hFF,
			8'h1C, 8'h80, 8'h7F
		};
		foreach (seq[i]) begin
			send_byte(seq[i]);
		end
	endtask

	task automatic test_tiny_screen();
		settle();
		write_screen(SIZE_BITS'(CURSOR_MARGIN), '0);
		send_byte(8'h0B);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h08);
		send_byte(8'h01);
		send_byte(8'h01);
	endtask

	task automatic test_random_rounds(input int mode);
		int target;
		case (mode)
			0: begin
				tx_idle_pct = 7;
				rx_idle_pct = 55;
			end
			1: begin
				tx_idle_pct = 55;
				rx_idle_pct = 7;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
		endcase
		for (int r = 0; r < 4; r++) begin
			settle();
			write_screen(pick_size(mode * 4 + r), pick_size(mode * 4 + r + 3));
			target = bytes_sent + 160;
			while (bytes_sent < target) begin
				send_random_unit();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_sync_and_buttons();
		test_tiny_screen();
		for (int m = 0; m < 3; m++) begin
			test_random_rounds(m);
		end
		settle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
